// File: hdl/vump_pkg.sv
// Package for the vector unpack and masked write block.
// Holds the transaction structs, format codes and register indexes.
// No dependencies.
package vump_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FORMAT   = 2'd0,
    CFG_UNSIGNED = 2'd1,
    CFG_MASK_EN  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    FMT_S32  = 4'd0,
    FMT_S16  = 4'd1,
    FMT_S8   = 4'd2,
    FMT_V232 = 4'd4,
    FMT_V216 = 4'd5,
    FMT_V28  = 4'd6,
    FMT_V332 = 4'd8,
    FMT_V316 = 4'd9,
    FMT_V38  = 4'd10,
    FMT_V432 = 4'd12,
    FMT_V416 = 4'd13,
    FMT_V48  = 4'd14,
    FMT_V45  = 4'd15
  } fmt_e;

  typedef struct packed {
    logic [63:0] src_low;
    logic [63:0] src_high;
    logic [63:0] old_dest_low;
    logic [63:0] old_dest_high;
    logic [63:0] keep_new_low;
    logic [63:0] keep_new_high;
    logic [63:0] keep_old_low;
    logic [63:0] keep_old_high;
    logic [63:0] fill_low;
    logic [63:0] fill_high;
  } vump_in_t;

  typedef struct packed {
    logic [63:0] out_low;
    logic [63:0] out_high;
    logic        bad_format;
  } vump_out_t;

endpackage

// File: hdl/vector_unpack_masked_write.sv
// Top level of the vector unpack and masked write block: three-stage pipeline.
// Depends on vump_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------
//  command  | start_i, busy_o    | item_i   (vump_in_t)
//  result   | done_o (strobe)    | result_o (vump_out_t)
//  config   | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// One transaction per cycle while busy_o is low; each result is registered through the
// capture, unpack and merge register stages before it appears on result_o.
// busy_o is high for the first cycle after reset and low from then on.
// Results are strobed for one cycle; the receiver cannot stall the pipeline.
module vector_unpack_masked_write
  import vump_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  vump_in_t            item_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                done_o,
  output vump_out_t           result_o
);

  logic [3:0] fmt_q;
  logic       unsigned_q;
  logic       mask_en_q;
  logic       busy_q;

  // stage 1: capture
  logic       s1_valid_q;
  vump_in_t   s1_item_q;
  logic [3:0] s1_fmt_q;
  logic       s1_zero_q;
  logic       s1_mask_q;

  // stage 2: unpacked lanes
  logic        s2_valid_q;
  logic [31:0] s2_lane_q [4];
  logic        s2_bad_q;
  logic        s2_mask_q;
  vump_in_t    s2_item_q;

  // stage 3: merged result
  logic      s3_valid_q;
  vump_out_t s3_res_q;

  logic        accept;
  logic [31:0] lane_d [4];
  logic        bad_d;
  logic [31:0] sw [4];
  logic [31:0] hw [4];
  logic [31:0] bw [4];
  logic [15:0] col;
  logic [63:0] res_lo;
  logic [63:0] res_hi;
  vump_out_t   res_d;

  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q      <= FMT_S32;
      unsigned_q <= 1'b0;
      mask_en_q  <= 1'b0;
      busy_q     <= 1'b1;
    end else begin
      busy_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FORMAT:   fmt_q      <= cfg_data_i[3:0];
          CFG_UNSIGNED: unsigned_q <= cfg_data_i[0];
          CFG_MASK_EN:  mask_en_q  <= cfg_data_i[0];
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= item_i;
      s1_fmt_q  <= fmt_q;
      s1_zero_q <= unsigned_q;
      s1_mask_q <= mask_en_q;
    end
    if (s1_valid_q) begin
      s2_lane_q <= lane_d;
      s2_bad_q  <= bad_d;
      s2_mask_q <= s1_mask_q;
      s2_item_q <= s1_item_q;
    end
    if (s2_valid_q) begin
      s3_res_q <= res_d;
    end
  end

  always_comb begin
    sw[0] = s1_item_q.src_low[31:0];
    sw[1] = s1_item_q.src_low[63:32];
    sw[2] = s1_item_q.src_high[31:0];
    sw[3] = s1_item_q.src_high[63:32];
    for (int i = 0; i < 4; i++) begin
      hw[i] = {{16{s1_item_q.src_low[16*i+15] & ~s1_zero_q}}, s1_item_q.src_low[16*i +: 16]};
      bw[i] = {{24{s1_item_q.src_low[8*i+7] & ~s1_zero_q}}, s1_item_q.src_low[8*i +: 8]};
    end
    col   = s1_item_q.src_low[15:0];
    bad_d = 1'b0;
    lane_d = sw;
    unique case (s1_fmt_q) inside
      FMT_S32: lane_d = '{sw[0], sw[0], sw[0], sw[0]};
      FMT_S16: lane_d = '{hw[0], hw[0], hw[0], hw[0]};
      FMT_S8:  lane_d = '{bw[0], bw[0], bw[0], bw[0]};
      FMT_V232: lane_d = '{sw[0], sw[1], sw[0], 32'd0};
      FMT_V216: lane_d = '{hw[0], hw[1], hw[0], hw[1]};
      FMT_V28:  lane_d = '{bw[0], bw[1], bw[0], bw[1]};
      FMT_V332: lane_d = '{sw[0], sw[1], sw[2], 32'd0};
      FMT_V316: lane_d = '{hw[0], hw[1], hw[2], 32'd0};
      FMT_V38, FMT_V48: lane_d = bw;
      FMT_V432: lane_d = sw;
      FMT_V416: lane_d = hw;
      FMT_V45: lane_d = '{{24'd0, col[4:0], 3'd0}, {24'd0, col[9:5], 3'd0},
                          {24'd0, col[14:10], 3'd0}, {24'd0, col[15], 7'd0}};
      default: bad_d = 1'b1;
    endcase
  end

  always_comb begin
    res_lo = {s2_lane_q[1], s2_lane_q[0]};
    res_hi = {s2_lane_q[3], s2_lane_q[2]};
    if (s2_mask_q) begin
      res_lo = (res_lo & s2_item_q.keep_new_low) |
               (s2_item_q.old_dest_low & s2_item_q.keep_old_low) | s2_item_q.fill_low;
      res_hi = (res_hi & s2_item_q.keep_new_high) |
               (s2_item_q.old_dest_high & s2_item_q.keep_old_high) | s2_item_q.fill_high;
    end
    res_d.out_low    = res_lo;
    res_d.out_high   = res_hi;
    res_d.bad_format = s2_bad_q;
  end

  assign done_o   = s3_valid_q;
  assign result_o = s3_res_q;

endmodule

// File: hdl/vump_checker.sv
// Port-level checker for vector_unpack_masked_write, attached by bind.
// Depends on vump_pkg.
module vump_checker
  import vump_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_o,
  input vump_in_t  item_i,
  input logic      done_o,
  input vump_out_t result_o
);

  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 done_o)
    else $error("transaction accepted but no result three cycles later");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##3 !done_o)
    else $error("result strobe without an accepted transaction");

  a_busy_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held for more than one cycle");

  a_item_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> !$isunknown(item_i))
    else $error("transaction accepted with unknown payload bits");

  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(result_o))
    else $error("result strobed with unknown payload bits");

endmodule

bind vector_unpack_masked_write vump_checker u_vump_checker (.*);
